// File: rtl/json_character_tokenizer_assert.svh
// assertion macros used by the checker file
`ifndef JSON_CHARACTER_TOKENIZER_ASSERT_SVH
`define JSON_CHARACTER_TOKENIZER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define JCT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define JCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/jct_pkg.sv
// types, constants and helpers of the json character tokenizer
`default_nettype none
package jct_pkg;

	localparam int MAGNITUDE_BITS  = 31;
	localparam int MAX_FRAC_DIGITS = 9;
	localparam int FRAC_W          = 4;
	localparam int POS_W           = 3;
	localparam int PROD_W          = MAGNITUDE_BITS + 4;

	localparam logic [MAGNITUDE_BITS-1:0] MAG_MAX = {MAGNITUDE_BITS{1'b1}};

	// packed output data width: char, magnitude, sign, fraction count, boolean
	localparam int OUT_FIELDS_W = 8 + MAGNITUDE_BITS + 1 + FRAC_W + 1;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// characters with a meaning to the lexer
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_COLON    = 8'h3A;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_POINT    = 8'h2E;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_T        = 8'h74;
	localparam logic [7:0] CH_R        = 8'h72;
	localparam logic [7:0] CH_U        = 8'h75;
	localparam logic [7:0] CH_E        = 8'h65;
	localparam logic [7:0] CH_F        = 8'h66;
	localparam logic [7:0] CH_A        = 8'h61;
	localparam logic [7:0] CH_L        = 8'h6C;
	localparam logic [7:0] CH_S        = 8'h73;

	localparam logic [POS_W-1:0] LEN_TRUE  = 3'd4;
	localparam logic [POS_W-1:0] LEN_FALSE = 3'd5;

	typedef enum logic [3:0] {
		KIND_LBRACE    = 4'd0,
		KIND_RBRACE    = 4'd1,
		KIND_LBRACKET  = 4'd2,
		KIND_RBRACKET  = 4'd3,
		KIND_COLON     = 4'd4,
		KIND_COMMA     = 4'd5,
		KIND_STR_CHAR  = 4'd6,
		KIND_STR_END   = 4'd7,
		KIND_INT       = 4'd8,
		KIND_DEC       = 4'd9,
		KIND_BOOL      = 4'd10,
		KIND_UNKNOWN   = 4'd11,
		KIND_NOT_ENDED = 4'd12
	} kind_t;

	typedef enum logic [5:0] {
		MODE_IDLE   = 6'b000001,
		MODE_STRING = 6'b000010,
		MODE_INT    = 6'b000100,
		MODE_FRAC   = 6'b001000,
		MODE_WORD   = 6'b010000,
		MODE_ERROR  = 6'b100000
	} mode_t;

	typedef logic [MAGNITUDE_BITS-1:0] mag_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        chv;
		mag_t              mag;
		logic              neg;
		logic [FRAC_W-1:0] frac;
		logic              bval;
		logic              last;
	} tok_t;

	// up to two tokens produced by one request
	typedef struct packed {
		logic [1:0] cnt;
		tok_t       tok0;
		tok_t       tok1;
	} lex_out_t;

	function automatic tok_t make_tok(input kind_t kind, input logic [7:0] chv,
			input mag_t mag, input logic neg, input logic [FRAC_W-1:0] frac,
			input logic bval);
		tok_t t;
		t.kind = kind;
		t.chv  = chv;
		t.mag  = mag;
		t.neg  = neg;
		t.frac = frac;
		t.bval = bval;
		t.last = 1'b0;
		return t;
	endfunction

	// expected letter of a keyword at a position
	function automatic logic [7:0] keyword_char(input logic is_true,
			input logic [POS_W-1:0] pos);
		logic [7:0] c;
		c = 8'h00;
		if (is_true) begin
			case (pos)
				3'd0: c = CH_T;
				3'd1: c = CH_R;
				3'd2: c = CH_U;
				3'd3: c = CH_E;
				default: c = 8'h00;
			endcase
		end else begin
			case (pos)
				3'd0: c = CH_F;
				3'd1: c = CH_A;
				3'd2: c = CH_L;
				3'd3: c = CH_S;
				3'd4: c = CH_E;
				default: c = 8'h00;
			endcase
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// File: rtl/jct_lexer.sv
// lexer state registers and single-pass next-state and token logic
`default_nettype none
module jct_lexer
	import jct_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] ch,
	input  wire logic       eot,
	output lex_out_t        res
);

	mode_t             mode_q;
	mag_t              mag_q;
	logic              neg_q;
	logic [FRAC_W-1:0] frac_q;
	logic [POS_W-1:0]  pos_q;
	logic              tru_q;

	mode_t             mode_c;
	mag_t              mag_c;
	logic              neg_c;
	logic [FRAC_W-1:0] frac_c;
	logic [POS_W-1:0]  pos_c;
	logic              tru_c;

	tok_t              e_mode, e_idle, e_eot;
	logic              v_mode, v_idle, v_eot;
	logic              do_idle;
	logic              is_digit;
	logic [PROD_W-1:0] prod;
	mag_t              mag_dig;
	logic [POS_W-1:0]  len;
	logic [POS_W-1:0]  pos_inc;
	tok_t              t0, t1;
	logic              v0, v1;

	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

	// saturating acc * 10 + digit
	assign prod = (PROD_W'(mag_q) << 3) + (PROD_W'(mag_q) << 1) + PROD_W'(ch[3:0]);
	assign mag_dig = (|prod[PROD_W-1:MAGNITUDE_BITS]) ? MAG_MAX : prod[MAGNITUDE_BITS-1:0];

	assign len     = tru_q ? LEN_TRUE : LEN_FALSE;
	assign pos_inc = pos_q + 1'b1;

	always_comb begin
		mode_c  = mode_q;
		mag_c   = mag_q;
		neg_c   = neg_q;
		frac_c  = frac_q;
		pos_c   = pos_q;
		tru_c   = tru_q;
		e_mode  = make_tok(KIND_UNKNOWN, 8'h00, '0, 1'b0, '0, 1'b0);
		e_idle  = e_mode;
		e_eot   = e_mode;
		v_mode  = 1'b0;
		v_idle  = 1'b0;
		v_eot   = 1'b0;
		do_idle = 1'b0;

		case (mode_q)
			MODE_STRING: begin
				v_mode = 1'b1;
				if (ch == CH_QUOTE) begin
					e_mode = make_tok(KIND_STR_END, 8'h00, '0, 1'b0, '0, 1'b0);
					mode_c = MODE_IDLE;
				end else begin
					e_mode = make_tok(KIND_STR_CHAR, ch, '0, 1'b0, '0, 1'b0);
				end
			end
			MODE_INT: begin
				if (is_digit) begin
					mag_c = mag_dig;
				end else if (ch == CH_POINT) begin
					mode_c = MODE_FRAC;
				end else begin
					v_mode  = 1'b1;
					e_mode  = make_tok(KIND_INT, 8'h00, mag_q, neg_q, '0, 1'b0);
					do_idle = 1'b1;
				end
			end
			MODE_FRAC: begin
				if (is_digit) begin
					if (frac_q < FRAC_W'(MAX_FRAC_DIGITS)) begin
						mag_c  = mag_dig;
						frac_c = frac_q + 1'b1;
					end
				end else begin
					v_mode  = 1'b1;
					e_mode  = make_tok(KIND_DEC, 8'h00, mag_q, neg_q, frac_q, 1'b0);
					do_idle = 1'b1;
				end
			end
			MODE_WORD: begin
				v_mode = 1'b1;
				if ((pos_q >= len) || (ch != keyword_char(tru_q, pos_q))) begin
					mode_c = MODE_ERROR;
				end else begin
					pos_c = pos_inc;
					if (pos_inc == len) begin
						e_mode = make_tok(KIND_BOOL, 8'h00, '0, 1'b0, '0, tru_q);
						mode_c = MODE_IDLE;
						pos_c  = '0;
						tru_c  = 1'b0;
					end else begin
						v_mode = 1'b0;
					end
				end
			end
			MODE_ERROR: begin
			end
			default: begin
				do_idle = 1'b1;
			end
		endcase

		// state leaving a string or word goes back to cleared values
		if (mode_c == MODE_IDLE) begin
			mag_c  = '0;
			neg_c  = 1'b0;
			frac_c = '0;
			pos_c  = '0;
			tru_c  = 1'b0;
		end

		if (do_idle) begin
			mode_c = MODE_IDLE;
			mag_c  = '0;
			neg_c  = 1'b0;
			frac_c = '0;
			pos_c  = '0;
			tru_c  = 1'b0;
			case (ch)
				CH_SPACE, CH_NEWLINE: begin
				end
				CH_QUOTE:    mode_c = MODE_STRING;
				CH_LBRACE: begin
					v_idle = 1'b1;
					e_idle = make_tok(KIND_LBRACE, 8'h00, '0, 1'b0, '0, 1'b0);
				end
				CH_RBRACE: begin
					v_idle = 1'b1;
					e_idle = make_tok(KIND_RBRACE, 8'h00, '0, 1'b0, '0, 1'b0);
				end
				CH_LBRACKET: begin
					v_idle = 1'b1;
					e_idle = make_tok(KIND_LBRACKET, 8'h00, '0, 1'b0, '0, 1'b0);
				end
				CH_RBRACKET: begin
					v_idle = 1'b1;
					e_idle = make_tok(KIND_RBRACKET, 8'h00, '0, 1'b0, '0, 1'b0);
				end
				CH_COLON: begin
					v_idle = 1'b1;
					e_idle = make_tok(KIND_COLON, 8'h00, '0, 1'b0, '0, 1'b0);
				end
				CH_COMMA: begin
					v_idle = 1'b1;
					e_idle = make_tok(KIND_COMMA, 8'h00, '0, 1'b0, '0, 1'b0);
				end
				CH_MINUS: begin
					mode_c = MODE_INT;
					neg_c  = 1'b1;
				end
				CH_T: begin
					mode_c = MODE_WORD;
					pos_c  = 3'd1;
					tru_c  = 1'b1;
				end
				CH_F: begin
					mode_c = MODE_WORD;
					pos_c  = 3'd1;
				end
				default: begin
					if (is_digit) begin
						mode_c = MODE_INT;
						mag_c  = MAGNITUDE_BITS'(ch[3:0]);
					end else begin
						v_idle = 1'b1;
						e_idle = make_tok(KIND_UNKNOWN, 8'h00, '0, 1'b0, '0, 1'b0);
						mode_c = MODE_ERROR;
					end
				end
			endcase
		end

		// end of text flushes what is pending
		if (eot) begin
			case (mode_c)
				MODE_INT: begin
					v_eot = 1'b1;
					e_eot = make_tok(KIND_INT, 8'h00, mag_c, neg_c, '0, 1'b0);
				end
				MODE_FRAC: begin
					v_eot = 1'b1;
					e_eot = make_tok(KIND_DEC, 8'h00, mag_c, neg_c, frac_c, 1'b0);
				end
				MODE_STRING: begin
					v_eot = 1'b1;
					e_eot = make_tok(KIND_NOT_ENDED, 8'h00, '0, 1'b0, '0, 1'b0);
				end
				MODE_WORD: begin
					v_eot = 1'b1;
				end
				default: begin
				end
			endcase
			mode_c = MODE_IDLE;
			mag_c  = '0;
			neg_c  = 1'b0;
			frac_c = '0;
			pos_c  = '0;
			tru_c  = 1'b0;
		end
	end

	// keep the first two tokens in order, a third is dropped
	always_comb begin
		if (v_mode) begin
			t0 = e_mode;
			v0 = 1'b1;
			t1 = v_idle ? e_idle : e_eot;
			v1 = v_idle | v_eot;
		end else if (v_idle) begin
			t0 = e_idle;
			v0 = 1'b1;
			t1 = e_eot;
			v1 = v_eot;
		end else begin
			t0 = e_eot;
			v0 = v_eot;
			t1 = e_eot;
			v1 = 1'b0;
		end
		t0.last = v0 & ~v1;
		t1.last = v1;
		res.tok0 = t0;
		res.tok1 = t1;
		res.cnt  = {v1, v0 & ~v1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			mag_q  <= '0;
			neg_q  <= 1'b0;
			frac_q <= '0;
			pos_q  <= '0;
			tru_q  <= 1'b0;
		end else if (step) begin
			mode_q <= mode_c;
			mag_q  <= mag_c;
			neg_q  <= neg_c;
			frac_q <= frac_c;
			pos_q  <= pos_c;
			tru_q  <= tru_c;
		end
	end

endmodule
`default_nettype wire

// File: rtl/jct_result_fifo.sv
// result queue taking up to two tokens and giving one per cycle while the sink is ready
`default_nettype none
module jct_result_fifo
	import jct_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire lex_out_t din,
	output logic          room,
	output logic          out_valid,
	input  wire logic     out_ready,
	output tok_t          dout
);

	tok_t                  mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic [1:0]            n_push;
	logic                  pop;

	assign n_push    = push ? din.cnt : 2'd0;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid & out_ready;
	assign room      = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
	assign dout      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem[wr_ptr_q] <= din.tok0;
		end
		if (n_push == 2'd2) begin
			mem[FIFO_PTR_W'(wr_ptr_q + 1'b1)] <= din.tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= FIFO_PTR_W'(wr_ptr_q + FIFO_PTR_W'(n_push));
			rd_ptr_q <= FIFO_PTR_W'(rd_ptr_q + FIFO_PTR_W'(pop));
			count_q  <= FIFO_CNT_W'(count_q + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop));
		end
	end

endmodule
`default_nettype wire

// File: rtl/json_character_tokenizer.sv
// json character tokenizer: one text byte per request in, one token per request out
// an accepted byte is held in the input stage, its tokens then pass the result queue
// throughput: one byte per cycle unless stalled; two tokens of a byte leave one at a time
// input stalls only while the four-entry result queue holds more than two tokens
// reset: arst_n asynchronous active low, lexer returns to idle and the queue empties
`default_nettype none
module json_character_tokenizer
	import jct_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input requests
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,   // [7:0] ch
	input  wire logic                  s_tlast,   // end_of_text
	// result requests
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // char_value, magnitude, negative,
	                                              // frac_digits, bool_value, zero pad
	output logic [3:0]                 m_tuser,   // [3:0] token_kind
	output logic                       m_tlast    // last token of its request
);

	// input stage: one held request
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       eot_s1;

	logic       room;
	logic       step;
	lex_out_t   lex_res;
	tok_t       head;

	// a held byte moves on when the queue can take two tokens
	assign step     = valid_s1 & room;
	assign s_tready = ~valid_s1 | step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1  <= s_tdata;
			eot_s1 <= s_tlast;
		end
	end

	// mode, number accumulator and keyword tracking, all updated in one pass
	jct_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ch     (ch_s1),
		.eot    (eot_s1),
		.res    (lex_res)
	);

	// result queue parts the lexer from a stalled sink
	jct_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.din       (lex_res),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.dout      (head)
	);

	// pack fields from the lowest bit up, zero fill to whole bytes
	assign m_tdata = OUT_DATA_W'({head.bval, head.frac, head.neg, head.mag, head.chv});
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule
`default_nettype wire

// File: rtl/jct_checker.sv
// port checker for the json character tokenizer and its bind
`default_nettype none
`include "json_character_tokenizer_assert.svh"
module jct_checker
	import jct_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic [3:0]            m_tuser
);

	`JCT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`JCT_ASSERT_NOW(a_char_zero, m_tvalid && (m_tuser != KIND_STR_CHAR), m_tdata[7:0] == 8'h00, "char value on non-char token")
	`JCT_ASSERT_NOW(a_frac_range, m_tvalid, m_tdata[8+MAGNITUDE_BITS+FRAC_W:9+MAGNITUDE_BITS] <= FRAC_W'(MAX_FRAC_DIGITS), "fraction count out of range")
	`JCT_ASSERT_NOW(a_num_zero, m_tvalid && (m_tuser != KIND_INT) && (m_tuser != KIND_DEC), m_tdata[8+MAGNITUDE_BITS:8] == '0, "number fields on non-number token")

endmodule

bind json_character_tokenizer jct_checker u_jct_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
